### rtl/bolip_pkg.sv
// Shared types and constants of the binary outline and isolated-point detector.
package bolip_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int DIM_W   = 9;
  localparam int FIELD_W = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int IROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W  = $clog2(MAX_HEIGHT);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0]       DIM_RESET        = 9'd250;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] column;
    logic               dot;
    logic               isolated;
    logic               outline;
    logic               last;
  } out_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic              fg;
    logic              first_col;
    logic              emit;
    logic              last;
    logic [OROW_W-1:0] orow;
    logic [COL_W-1:0]  ocol;
    logic              has_left;
    logic              has_right;
    logic              has_up;
    logic              has_down;
  } work_t;

endpackage

### rtl/bolip_ram.sv
// Generic simple dual-port RAM with registered read.
module bolip_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bolip_front.sv
// Front end: accepts items, tracks input and output raster positions, classifies.
module bolip_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic [bolip_pkg::DIM_W-1:0]  frame_width,
  input  logic [bolip_pkg::DIM_W-1:0]  frame_height,
  input  logic                         src_valid,
  output logic                         src_ready,
  input  bolip_pkg::in_t               src_data,
  input  logic                         queue_full,
  output logic                         push,
  output bolip_pkg::work_t             push_data
);

  logic [bolip_pkg::DIM_W-1:0]  w;
  logic [bolip_pkg::DIM_W-1:0]  h;
  logic [bolip_pkg::COL_W-1:0]  in_column;
  logic [bolip_pkg::IROW_W-1:0] in_row;
  logic [bolip_pkg::OROW_W-1:0] out_row;
  logic [bolip_pkg::COL_W-1:0]  out_col;
  logic                         accept;
  logic                         in_frame;
  logic                         ignore;
  logic                         emit;
  logic                         last;
  logic                         in_wrap;
  logic                         out_wrap;

  always_comb begin
    if (frame_width == '0) begin
      w = bolip_pkg::DIM_W'(1);
    end else if (frame_width > bolip_pkg::DIM_W'(bolip_pkg::MAX_WIDTH)) begin
      w = bolip_pkg::DIM_W'(bolip_pkg::MAX_WIDTH);
    end else begin
      w = frame_width;
    end
    if (frame_height == '0) begin
      h = bolip_pkg::DIM_W'(1);
    end else if (frame_height > bolip_pkg::DIM_W'(bolip_pkg::MAX_HEIGHT)) begin
      h = bolip_pkg::DIM_W'(bolip_pkg::MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
  end

  assign src_ready = !queue_full;
  assign accept    = src_valid && src_ready;
  assign in_frame  = bolip_pkg::DIM_W'(in_row) < h;
  // drop a flush that arrives before the frame is complete
  assign ignore    = (src_data.mode == bolip_pkg::MODE_FLUSH) && in_frame;
  assign push      = accept && !ignore;

  // an output is due once the input is one row plus one pixel ahead
  assign emit = (in_row > bolip_pkg::IROW_W'(1)) ||
                ((in_row == bolip_pkg::IROW_W'(1)) && (in_column != '0));
  assign last = (bolip_pkg::DIM_W'(out_row) == h - bolip_pkg::DIM_W'(1)) &&
                (bolip_pkg::DIM_W'(out_col) == w - bolip_pkg::DIM_W'(1));

  assign in_wrap  = (bolip_pkg::DIM_W'(in_column) + bolip_pkg::DIM_W'(1)) >= w;
  assign out_wrap = (bolip_pkg::DIM_W'(out_col) + bolip_pkg::DIM_W'(1)) >= w;

  always_comb begin
    push_data.col       = in_column;
    push_data.fg        = in_frame && (src_data.mode == bolip_pkg::MODE_PIXEL) &&
                          (src_data.pixel == '0);
    push_data.first_col = (in_column == '0);
    push_data.emit      = emit;
    push_data.last      = emit && last;
    push_data.orow      = out_row;
    push_data.ocol      = out_col;
    push_data.has_left  = (out_col != '0);
    push_data.has_right = !out_wrap;
    push_data.has_up    = (out_row != '0);
    push_data.has_down  = (bolip_pkg::DIM_W'(out_row) + bolip_pkg::DIM_W'(1)) < h;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column <= '0;
      in_row    <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (push) begin
      if (emit && last) begin
        // frame done: start the next one
        in_column <= '0;
        in_row    <= '0;
        out_row   <= '0;
        out_col   <= '0;
      end else begin
        if (in_wrap) begin
          in_column <= '0;
          in_row    <= in_row + bolip_pkg::IROW_W'(1);
        end else begin
          in_column <= in_column + bolip_pkg::COL_W'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + bolip_pkg::OROW_W'(1);
          end else begin
            out_col <= out_col + bolip_pkg::COL_W'(1);
          end
        end
      end
    end
  end

endmodule

### rtl/bolip_queue.sv
// Short register queue between the front and the back.
module bolip_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bolip_pkg::work_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output bolip_pkg::work_t head
);

  bolip_pkg::work_t              slots [bolip_pkg::QUEUE_DEPTH];
  logic [bolip_pkg::QPTR_W-1:0]  wr_ptr;
  logic [bolip_pkg::QPTR_W-1:0]  rd_ptr;
  logic [bolip_pkg::QCNT_W-1:0]  count;

  assign full       = (count == bolip_pkg::QCNT_W'(bolip_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bolip_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bolip_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + bolip_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - bolip_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/bolip_back.sv
// Back end: line stores, 3x3 window and the outline / isolated-point judgement.
module bolip_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             head_valid,
  input  bolip_pkg::work_t head,
  output logic             pop,
  output logic             dst_valid,
  input  logic             dst_ready,
  output bolip_pkg::out_t  dst_data
);

  bolip_pkg::work_t e;
  logic             e_valid;
  logic             e_fire;
  logic             out_free;
  logic [1:0]       rdata;
  logic [1:0]       wdata;
  logic [1:0]       lines;
  logic             byp;
  logic [1:0]       byp_data;
  logic [8:0]       win;
  logic [8:0]       shifted;
  logic [2:0]       cl;
  logic [2:0]       cc;
  logic [2:0]       cr;
  logic             any;
  logic             dot;

  assign out_free = !dst_valid || dst_ready;
  assign e_fire   = e_valid && (!e.emit || out_free);
  assign pop      = head_valid && (!e_valid || e_fire);

  // upper line in bit 1, middle line in bit 0
  assign lines   = byp ? byp_data : rdata;
  assign wdata   = {lines[0], e.fg};
  assign shifted = {e.fg, lines[0], lines[1], win[8:3]};

  bolip_ram #(
    .WIDTH (2),
    .DEPTH (bolip_pkg::MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (e_fire),
    .waddr (e.col),
    .wdata (wdata),
    .re    (pop),
    .raddr (head.col),
    .rdata (rdata)
  );

  always_comb begin
    // at column zero the centre sits in the newest column of the old window
    if (e.first_col) begin
      cl = win[5:3];
      cc = win[8:6];
      cr = 3'b000;
    end else begin
      cl = shifted[2:0];
      cc = shifted[5:3];
      cr = shifted[8:6];
    end
    dot = cc[1];
    any = (e.has_left  && ((cl[0] && e.has_up) || cl[1] || (cl[2] && e.has_down))) ||
          (cc[0] && e.has_up) || (cc[2] && e.has_down) ||
          (e.has_right && ((cr[0] && e.has_up) || cr[1] || (cr[2] && e.has_down)));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e        <= head;
      // forward a write to the column being read in the same cycle
      byp      <= e_fire && (e.col == head.col);
      byp_data <= wdata;
    end
    if (e_fire && e.emit) begin
      dst_data.row      <= bolip_pkg::FIELD_W'(e.orow);
      dst_data.column   <= bolip_pkg::FIELD_W'(e.ocol);
      dst_data.dot      <= dot;
      dst_data.isolated <= dot && !any;
      dst_data.outline  <= !dot && any;
      dst_data.last     <= e.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      dst_valid <= 1'b0;
      win       <= '0;
    end else begin
      if (pop) begin
        e_valid <= 1'b1;
      end else if (e_fire) begin
        e_valid <= 1'b0;
      end
      if (e_fire && e.emit) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
      if (restart) begin
        win <= '0;
      end else if (e_fire) begin
        win <= e.last ? 9'd0 : shifted;
      end
    end
  end

endmodule

### rtl/binary_outline_isolated_point_3x3.sv
// Binary outline and isolated-point detector over a 3x3 window, raster pixel stream.
//
// Pixels arrive in raster order, one item per clock while src_ready is high; a zero
// byte is a foreground dot. Each pixel comes back with its row, column, dot,
// isolated, outline and last flags once the input has moved one row plus one pixel
// past it, so the final frame_width + 1 results are pushed out by flush items (a
// flush given before the frame is complete is dropped). The block sustains one item
// per cycle while dst_ready does not stall the output; the front classifies an item
// in its accept cycle, a four-entry queue decouples it from the back, and the back
// issues the registered read of the shared line-store RAM (two bits per column) as
// it takes the item from the queue, then updates the window and the output
// register as the item leaves the back's work register. A write to either frame
// register restarts the frame.
module binary_outline_isolated_point_3x3 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              src_valid,
  output logic                              src_ready,
  input  bolip_pkg::in_t                    src_data,
  output logic                              dst_valid,
  input  logic                              dst_ready,
  output bolip_pkg::out_t                   dst_data,
  input  logic                              cfg_we,
  input  logic [bolip_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bolip_pkg::DIM_W-1:0]       cfg_data
);

  logic [bolip_pkg::DIM_W-1:0] frame_width;
  logic [bolip_pkg::DIM_W-1:0] frame_height;
  logic                        queue_full;
  logic                        push;
  bolip_pkg::work_t            push_data;
  logic                        pop;
  logic                        head_valid;
  bolip_pkg::work_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bolip_pkg::DIM_RESET;
      frame_height <= bolip_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bolip_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bolip_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bolip_front u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_we),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .src_valid    (src_valid),
    .src_ready    (src_ready),
    .src_data     (src_data),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  bolip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bolip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_we),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .dst_data   (dst_data)
  );

endmodule

### test/binary_outline_isolated_point_3x3_test.sv
// Self-checking testbench for the 3x3 binary outline and isolated-point detector.
module binary_outline_isolated_point_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 60;
  localparam int REPORT_LIMIT  = 10;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              src_valid;
  logic                              src_ready;
  bolip_pkg::in_t                    src_data;
  logic                              dst_valid;
  logic                              dst_ready;
  bolip_pkg::out_t                   dst_data;
  logic                              cfg_we;
  logic [bolip_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bolip_pkg::DIM_W-1:0]       cfg_data;

  bit src_idle;
  bit dst_idle;

  int cycle_count     = 0;
  int error_count     = 0;
  int items_sent      = 0;
  int effective_items = 0;
  int results_checked = 0;
  int frames_done     = 0;
  int isolated_seen   = 0;
  int outline_seen    = 0;

  // Detector state as the testbench tracks it
  logic [bolip_pkg::DIM_W-1:0] width_setting;
  logic [bolip_pkg::DIM_W-1:0] height_setting;
  logic                        upper_bits  [0:bolip_pkg::MAX_WIDTH-1];
  logic                        middle_bits [0:bolip_pkg::MAX_WIDTH-1];
  logic [8:0]                  window;
  int unsigned                 next_col;
  int unsigned                 next_row;
  int unsigned                 next_out;
  bolip_pkg::out_t             expected_pixels [$];

  binary_outline_isolated_point_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  function automatic int unsigned clamp_dim(input logic [bolip_pkg::DIM_W-1:0] v,
                                            input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_cols();
    return clamp_dim(width_setting, bolip_pkg::MAX_WIDTH);
  endfunction

  function automatic int unsigned frame_rows();
    return clamp_dim(height_setting, bolip_pkg::MAX_HEIGHT);
  endfunction

  function automatic int frame_pixels();
    return int'(frame_cols() * frame_rows());
  endfunction

  function automatic void clear_frame();
    window   = '0;
    next_col = 0;
    next_row = 0;
    next_out = 0;
  endfunction

  function automatic void reset_model();
    width_setting  = bolip_pkg::DIM_RESET;
    height_setting = bolip_pkg::DIM_RESET;
    for (int i = 0; i < bolip_pkg::MAX_WIDTH; i++) begin
      upper_bits[i]  = 1'b0;
      middle_bits[i] = 1'b0;
    end
    clear_frame();
  endfunction

  function automatic void apply_register(input logic [bolip_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [bolip_pkg::DIM_W-1:0] val);
    if (idx == bolip_pkg::CFG_FRAME_WIDTH) begin
      width_setting = val;
    end else begin
      height_setting = val;
    end
    clear_frame();
  endfunction

  // Window bit k*3+r: column k (0 oldest), row r (0 top); off-frame neighbours are background.
  function automatic logic any_neighbour(input logic [8:0] win, input int kc,
                                         input int unsigned orow, input int unsigned ocol,
                                         input int unsigned fw, input int unsigned fh);
    logic found;
    int   k;
    found = 1'b0;
    for (int dk = -1; dk <= 1; dk++) begin
      if (dk < 0 && ocol < 1) continue;
      if (dk > 0 && ocol + 1 >= fw) continue;
      for (int r = 0; r <= 2; r++) begin
        if (dk == 0 && r == 1) continue;
        if (r == 0 && orow < 1) continue;
        if (r == 2 && orow + 1 >= fh) continue;
        k = kc + dk;
        if (k >= 0 && k <= 2) found |= win[k*3 + r];
      end
    end
    return found;
  endfunction

  // Advance the tracked detector by one item; returns 0 for a dropped early flush.
  function automatic bit classify_pixel(input logic mode,
                                        input logic [bolip_pkg::FIELD_W-1:0] pix);
    int unsigned                 fw, fh, total, pos, orow, ocol;
    logic                        fg, up, mid, dot, near;
    logic [8:0]                  prior, shifted;
    logic [bolip_pkg::COL_W-1:0] slot;
    bolip_pkg::out_t             res;
    bit                          emitted;
    fw    = frame_cols();
    fh    = frame_rows();
    total = fw * fh;
    pos   = next_row * fw + next_col;
    if (mode == bolip_pkg::MODE_FLUSH && pos < total) return 1'b0;
    fg      = (pos < total && mode == bolip_pkg::MODE_PIXEL && pix == '0);
    slot    = next_col[bolip_pkg::COL_W-1:0];
    up      = upper_bits[slot];
    mid     = middle_bits[slot];
    prior   = window;
    shifted = {fg, mid, up, prior[8:3]};
    upper_bits[slot]  = mid;
    middle_bits[slot] = fg;
    emitted = 1'b0;
    if (pos >= fw + 1 && next_out < total) begin
      orow = next_out / fw;
      ocol = next_out % fw;
      // at the start of a row the centre still sits in the newest column of the old window
      if (next_col == 0) begin
        dot  = prior[7];
        near = any_neighbour(prior, 2, orow, ocol, fw, fh);
      end else begin
        dot  = shifted[4];
        near = any_neighbour(shifted, 1, orow, ocol, fw, fh);
      end
      res.row      = orow[bolip_pkg::FIELD_W-1:0];
      res.column   = ocol[bolip_pkg::FIELD_W-1:0];
      res.dot      = dot;
      res.isolated = dot & ~near;
      res.outline  = ~dot & near;
      res.last     = (next_out + 1 == total);
      expected_pixels.push_back(res);
      emitted = 1'b1;
    end
    window = shifted;
    next_col++;
    if (next_col >= fw) begin
      next_col = 0;
      next_row++;
    end
    if (emitted) begin
      next_out++;
      if (next_out >= total) clear_frame();
    end
    return 1'b1;
  endfunction

  function automatic logic [bolip_pkg::FIELD_W-1:0] random_byte();
    return bolip_pkg::FIELD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [bolip_pkg::FIELD_W-1:0] random_shade(input int fg_pct);
    logic [bolip_pkg::FIELD_W-1:0] pix;
    pix = bolip_pkg::FIELD_W'($urandom_range(1, 255));
    if ($urandom_range(0, 99) < fg_pct) pix = '0;
    return pix;
  endfunction

  function automatic logic [bolip_pkg::DIM_W-1:0] pick_dim(input int top);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return bolip_pkg::DIM_W'(1);
      default: return bolip_pkg::DIM_W'($urandom_range(2, top));
    endcase
  endfunction

  task automatic send_item(input logic mode, input logic [bolip_pkg::FIELD_W-1:0] pix);
    bolip_pkg::in_t item;
    int             gap;
    item.mode  = mode;
    item.pixel = pix;
    gap = src_idle ? int'($urandom_range(0, 4)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= item;
    do @(posedge clk); while (!src_ready);
    items_sent++;
    if (classify_pixel(item.mode, item.pixel)) effective_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Let items that give no result leave the pipeline before touching a register
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bolip_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bolip_pkg::DIM_W-1:0] val);
    @(negedge clk);
    src_valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
  endtask

  // Push out the last row plus one pixel; some of the trailing items may be surplus pixels
  task automatic flush_frame(input int surplus_pct);
    for (int i = 0; i <= frame_cols(); i++) begin
      if ($urandom_range(0, 99) < surplus_pct) begin
        send_item(bolip_pkg::MODE_PIXEL, random_byte());
      end else begin
        send_item(bolip_pkg::MODE_FLUSH, random_byte());
      end
    end
  endtask

  task automatic push_frame(input int fg_pct, input int noise_pct, input bit pause_mid,
                            input int stop_at);
    int total;
    total = frame_pixels();
    for (int i = 0; i < total; i++) begin
      if (stop_at >= 0 && i == stop_at) return;
      if (pause_mid && i == total / 2) drain();
      // early flushes are dropped by the block
      if ($urandom_range(0, 99) < noise_pct) send_item(bolip_pkg::MODE_FLUSH, random_byte());
      send_item(bolip_pkg::MODE_PIXEL, random_shade(fg_pct));
    end
    flush_frame(noise_pct);
  endtask

  task automatic test_reset_defaults();
    // part of a frame at the reset size, cut short by the next register write
    for (int i = 0; i < 253; i++) begin
      send_item(bolip_pkg::MODE_PIXEL, random_shade(25));
    end
    settle();
  endtask

  task automatic test_single_pixel();
    settle();
    write_reg(bolip_pkg::CFG_FRAME_WIDTH, '0);
    write_reg(bolip_pkg::CFG_FRAME_HEIGHT, '0);
    send_item(bolip_pkg::MODE_FLUSH, 8'hA5);
    send_item(bolip_pkg::MODE_PIXEL, 8'h00);
    send_item(bolip_pkg::MODE_FLUSH, 8'h00);
    send_item(bolip_pkg::MODE_PIXEL, 8'h00);
    send_item(bolip_pkg::MODE_PIXEL, 8'hFF);
    send_item(bolip_pkg::MODE_FLUSH, 8'h5A);
    send_item(bolip_pkg::MODE_FLUSH, 8'hFF);
  endtask

  task automatic test_window_patterns();
    settle();
    write_reg(bolip_pkg::CFG_FRAME_WIDTH, bolip_pkg::DIM_W'(3));
    write_reg(bolip_pkg::CFG_FRAME_HEIGHT, bolip_pkg::DIM_W'(3));
    // lone dot in the centre, ringed by outline pixels; hold off until results catch up
    for (int i = 0; i < 9; i++) begin
      if (i == 4) drain();
      send_item(bolip_pkg::MODE_PIXEL, (i == 4) ? 8'h00 : ((i % 2) ? 8'h01 : 8'hFE));
    end
    flush_frame(0);
    settle();
    write_reg(bolip_pkg::CFG_FRAME_WIDTH, bolip_pkg::DIM_W'(2));
    write_reg(bolip_pkg::CFG_FRAME_HEIGHT, bolip_pkg::DIM_W'(2));
    for (int i = 0; i < 4; i++) begin
      send_item(bolip_pkg::MODE_PIXEL, 8'h00);
    end
    flush_frame(50);
  endtask

  task automatic test_extreme_sizes();
    settle();
    // an oversized width saturates at the widest line; stop early in the second row
    write_reg(bolip_pkg::CFG_FRAME_WIDTH, 9'h1FF);
    write_reg(bolip_pkg::CFG_FRAME_HEIGHT, 9'd3);
    push_frame(30, 0, 1'b0, 260);
    settle();
    write_reg(bolip_pkg::CFG_FRAME_HEIGHT, height_setting);
  endtask

  task automatic test_random_frames();
    int start;
    int abort_at;
    int fg_pct;
    start = effective_items;
    while (effective_items - start < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      dst_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        settle();
        write_reg(bolip_pkg::CFG_FRAME_WIDTH, pick_dim(12));
        write_reg(bolip_pkg::CFG_FRAME_HEIGHT, pick_dim(8));
      end
      case ($urandom_range(0, 4))
        0:       fg_pct = 0;
        1:       fg_pct = 100;
        default: fg_pct = int'($urandom_range(5, 60));
      endcase
      if ($urandom_range(0, 9) == 0) begin
        abort_at = int'($urandom_range(0, frame_pixels() - 1));
      end else begin
        abort_at = -1;
      end
      push_frame(fg_pct, int'($urandom_range(0, 1)) * 5, $urandom_range(0, 5) == 0, abort_at);
      if (abort_at >= 0) begin
        // restart the broken frame by rewriting one register
        settle();
        if ($urandom_range(0, 1)) begin
          write_reg(bolip_pkg::CFG_FRAME_WIDTH, width_setting);
        end else begin
          write_reg(bolip_pkg::CFG_FRAME_HEIGHT, height_setting);
        end
      end
    end
    src_idle = 1'b1;
    dst_idle = 1'b1;
  endtask

  initial begin : result_check
    bolip_pkg::out_t want;
    int              stall;
    dst_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = dst_idle ? int'($urandom_range(0, 4)) : 0;
      if (stall > 0) begin
        dst_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dst_ready <= 1'b1;
      do @(posedge clk); while (rst || !dst_valid);
      if (expected_pixels.size() == 0) begin
        log_error($sformatf("result with nothing pending: row %0d column %0d",
                            dst_data.row, dst_data.column));
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (dst_data.row !== want.row || dst_data.column !== want.column ||
            dst_data.dot !== want.dot || dst_data.isolated !== want.isolated ||
            dst_data.outline !== want.outline || dst_data.last !== want.last) begin
          log_error($sformatf({"row/column/dot/isolated/outline/last expected ",
                               "%0d/%0d/%b/%b/%b/%b, got %0d/%0d/%b/%b/%b/%b"},
                              want.row, want.column, want.dot, want.isolated,
                              want.outline, want.last, dst_data.row, dst_data.column,
                              dst_data.dot, dst_data.isolated, dst_data.outline,
                              dst_data.last));
        end
        if (want.last) frames_done++;
        if (want.isolated) isolated_seen++;
        if (want.outline) outline_seen++;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main
    int waited;
    rst       = 1'b1;
    src_valid = 1'b0;
    src_data  = '0;
    cfg_we    = 1'b0;
    cfg_index = bolip_pkg::CFG_FRAME_WIDTH;
    cfg_data  = '0;
    src_idle  = 1'b1;
    dst_idle  = 1'b1;
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_single_pixel();
    test_window_patterns();
    test_extreme_sizes();
    test_random_frames();

    @(negedge clk);
    src_valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      log_error($sformatf("%0d results never arrived", expected_pixels.size()));
    end

    $display("Sent %0d items (%0d not dropped), checked %0d results over %0d whole frames",
             items_sent, effective_items, results_checked, frames_done);
    $display("Saw %0d isolated points and %0d outline pixels; %0d errors",
             isolated_seen, outline_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
